### rtl/core/imc_pkg.sv
// Shared types and constants for the map cache forwarder.
// Used by imc_cache, itr_map_cache_forwarder and imc_checker.
`default_nettype none

package imc_pkg;

  localparam int unsigned CacheEntriesDef = 32;
  localparam int unsigned QueueDepthDef   = 16;
  localparam int unsigned TagBitsDef      = 16;

  localparam int unsigned AddrBits    = 32;
  localparam int unsigned OutTagBits  = 16;
  localparam int unsigned CfgIdxBits  = 2;

  typedef enum logic [1:0] {
    KIND_FWD  = 2'd0,
    KIND_REQ  = 2'd1,
    KIND_DROP = 2'd2
  } kind_e;

  localparam logic [CfgIdxBits-1:0] REG_OWN_ADDRESS   = 2'd0;
  localparam logic [CfgIdxBits-1:0] REG_MAPDB_ADDRESS = 2'd1;
  localparam logic [CfgIdxBits-1:0] REG_CACHE_TTL     = 2'd2;

  typedef struct packed {
    logic [AddrBits-1:0] expiry;
    logic [AddrBits-1:0] rloc;
    logic [AddrBits-1:0] eid;
  } cache_entry_t;

  typedef struct packed {
    logic start;
    logic purge;
    logic insert;
  } cache_cmd_t;

  typedef struct packed {
    logic                done;
    logic                hit_s;
    logic                hit_d;
    logic [AddrBits-1:0] rloc_s;
    logic [AddrBits-1:0] rloc_d;
  } cache_res_t;

  typedef struct packed {
    kind_e                 kind;
    logic [OutTagBits-1:0] tag;
    logic [AddrBits-1:0]   src;
    logic [AddrBits-1:0]   dst;
    logic [AddrBits-1:0]   reid;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/itr_map_cache_forwarder.sv
// Top level of the map cache forwarder: control sequencer, pending queue
// memory and result register. Uses imc_pkg, imc_cache and imc_ram.
//
// Usage: a packet transaction is accepted when start is high and busy is low.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i while
// the block is idle; index 0 is the own address, 1 the mapping server address
// and 2 the cache lifetime. Results leave one per cycle on the result ports,
// marked by result_valid_o, with last_o set on the final result of a
// transaction. The receiver cannot stall; every result is shown for exactly
// one cycle.
// Sequence: every transaction starts with one scan of the cache memory, one
// entry per cycle, which purges expired entries and looks up both
// identifiers. A data packet that misses then sends its map requests and is
// queued, or dropped when the queue is full. A map reply with a nonzero
// locator inserts the mapping and rescans the cache for each queued packet;
// a reply with a zero locator drops each queued packet that names the
// replied identifier. The cache memory has a single read port, which sets
// this sequence. Each result is held until the next one or the end of the
// transaction is known and is then registered onto the result ports.
// Reset clears the valid bits, the replacement head, the queue count and the
// registers; no clearing pass is needed.
`default_nettype none

module itr_map_cache_forwarder
  import imc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES = CacheEntriesDef,
  parameter int unsigned QUEUE_DEPTH   = QueueDepthDef,
  parameter int unsigned TAG_BITS      = TagBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [AddrBits-1:0]   cfg_wdata_i,
  input  wire logic [AddrBits-1:0]   src_addr_i,
  input  wire logic [AddrBits-1:0]   dst_addr_i,
  input  wire logic [OutTagBits-1:0] packet_tag_i,
  input  wire logic [AddrBits-1:0]   now_i,
  input  wire logic [AddrBits-1:0]   reply_eid_i,
  input  wire logic [AddrBits-1:0]   reply_rloc_i,
  output logic                       result_valid_o,
  output logic [1:0]                 kind_o,
  output logic [OutTagBits-1:0]      out_tag_o,
  output logic [AddrBits-1:0]        out_src_o,
  output logic [AddrBits-1:0]        out_dst_o,
  output logic [AddrBits-1:0]        request_eid_o,
  output logic                       last_o
);

  localparam int unsigned Qa = $clog2(QUEUE_DEPTH);
  localparam int unsigned Qc = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned Qw = 2 * AddrBits + TAG_BITS;
  localparam logic [Qc-1:0] QueueFull = Qc'(QUEUE_DEPTH);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_SCAN   = 13'b0000000000010,
    S_REQS   = 13'b0000000000100,
    S_REQD   = 13'b0000000001000,
    S_ENQ    = 13'b0000000010000,
    S_INSERT = 13'b0000000100000,
    S_FREAD  = 13'b0000001000000,
    S_FWAIT  = 13'b0000010000000,
    S_FSCAN  = 13'b0000100000000,
    S_DREAD  = 13'b0001000000000,
    S_DWAIT  = 13'b0010000000000,
    S_FDONE  = 13'b0100000000000,
    S_FINISH = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  logic [AddrBits-1:0] own_q, mapdb_q, ttl_q;
  logic [AddrBits-1:0] src_q, dst_q, now_q, reid_q, rrloc_q;
  logic [TAG_BITS-1:0] tag_q;
  logic                reply_q, stray_q;
  logic [Qc-1:0]       count_q, count_d, r_q, r_d, w_q, w_d;

  cache_cmd_t          cmd;
  cache_res_t          res;
  logic [AddrBits-1:0] key_s, key_d;

  logic                q_we, q_re;
  logic [Qa-1:0]       q_waddr;
  logic [Qw-1:0]       q_wdata, q_rdata;
  logic [AddrBits-1:0] q_src, q_dst;
  logic [TAG_BITS-1:0] q_tag;

  logic    emit_v, fin;
  result_t emit_r;
  logic    pend_vld_q;
  result_t pend_q;
  logic    res_vld_q, last_q;
  result_t out_q;

  assign busy = (state_q != S_IDLE);

  assign q_src = q_rdata[Qw-1 -: AddrBits];
  assign q_dst = q_rdata[TAG_BITS +: AddrBits];
  assign q_tag = q_rdata[TAG_BITS-1:0];

  assign key_s = (state_q == S_IDLE) ? src_addr_i : q_src;
  assign key_d = (state_q == S_IDLE) ? dst_addr_i : q_dst;

  imc_cache #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_cache (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .key_s_i      (key_s),
    .key_d_i      (key_d),
    .now_i        (now_i),
    .ins_eid_i    (reid_q),
    .ins_rloc_i   (rrloc_q),
    .ins_expiry_i (now_q + ttl_q),
    .res_o        (res)
  );

  imc_ram #(
    .WIDTH (Qw),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .wr_en_i   (q_we),
    .wr_addr_i (q_waddr),
    .wr_data_i (q_wdata),
    .rd_en_i   (q_re),
    .rd_addr_i (r_q[Qa-1:0]),
    .rd_data_o (q_rdata)
  );

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    r_d     = r_q;
    w_d     = w_q;
    cmd     = '0;
    q_we    = 1'b0;
    q_re    = 1'b0;
    q_waddr = w_q[Qa-1:0];
    q_wdata = q_rdata;
    emit_v  = 1'b0;
    emit_r  = '{kind: KIND_DROP, tag: '0, src: '0, dst: '0, reid: '0};
    fin     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd.start = 1'b1;
          cmd.purge = 1'b1;
          r_d       = '0;
          w_d       = '0;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (res.done) begin
          if (reply_q) begin
            if (stray_q) begin
              state_d = S_FINISH;
            end else if (rrloc_q == '0) begin
              state_d = S_DREAD;
            end else begin
              state_d = S_INSERT;
            end
          end else if (res.hit_s && res.hit_d) begin
            emit_v  = 1'b1;
            emit_r  = '{kind: KIND_FWD, tag: OutTagBits'(tag_q), src: res.rloc_s,
                        dst: res.rloc_d, reid: '0};
            state_d = S_FINISH;
          end else begin
            state_d = S_REQS;
          end
        end
      end
      S_REQS: begin
        if (!res.hit_s) begin
          emit_v = 1'b1;
          emit_r = '{kind: KIND_REQ, tag: '0, src: own_q, dst: mapdb_q, reid: src_q};
        end
        state_d = S_REQD;
      end
      S_REQD: begin
        if (!res.hit_d) begin
          emit_v = 1'b1;
          emit_r = '{kind: KIND_REQ, tag: '0, src: own_q, dst: mapdb_q, reid: dst_q};
        end
        state_d = S_ENQ;
      end
      S_ENQ: begin
        if (count_q < QueueFull) begin
          q_we    = 1'b1;
          q_waddr = count_q[Qa-1:0];
          q_wdata = {src_q, dst_q, tag_q};
          count_d = count_q + 1'b1;
        end else begin
          emit_v = 1'b1;
          emit_r = '{kind: KIND_DROP, tag: OutTagBits'(tag_q), src: '0, dst: '0,
                     reid: '0};
        end
        state_d = S_FINISH;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_d    = S_FREAD;
      end
      S_FREAD: begin
        if (r_q == count_q) begin
          state_d = S_FDONE;
        end else begin
          q_re    = 1'b1;
          state_d = S_FWAIT;
        end
      end
      S_FWAIT: begin
        cmd.start = 1'b1;
        state_d   = S_FSCAN;
      end
      S_FSCAN: begin
        if (res.done) begin
          if (res.hit_s && res.hit_d) begin
            emit_v = 1'b1;
            emit_r = '{kind: KIND_FWD, tag: OutTagBits'(q_tag), src: res.rloc_s,
                       dst: res.rloc_d, reid: '0};
          end else begin
            q_we = 1'b1;
            w_d  = w_q + 1'b1;
          end
          r_d     = r_q + 1'b1;
          state_d = S_FREAD;
        end
      end
      S_DREAD: begin
        if (r_q == count_q) begin
          state_d = S_FDONE;
        end else begin
          q_re    = 1'b1;
          state_d = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if ((q_src == reid_q) || (q_dst == reid_q)) begin
          emit_v = 1'b1;
          emit_r = '{kind: KIND_DROP, tag: OutTagBits'(q_tag), src: '0, dst: '0,
                     reid: '0};
        end else begin
          q_we = 1'b1;
          w_d  = w_q + 1'b1;
        end
        r_d     = r_q + 1'b1;
        state_d = S_DREAD;
      end
      S_FDONE: begin
        count_d = w_q;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        fin     = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      r_q        <= '0;
      w_q        <= '0;
      own_q      <= '0;
      mapdb_q    <= '0;
      ttl_q      <= '0;
      pend_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      r_q       <= r_d;
      w_q       <= w_d;
      res_vld_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_OWN_ADDRESS:   own_q   <= cfg_wdata_i;
          REG_MAPDB_ADDRESS: mapdb_q <= cfg_wdata_i;
          REG_CACHE_TTL:     ttl_q   <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (emit_v) begin
        pend_vld_q <= 1'b1;
        res_vld_q  <= pend_vld_q;
      end else if (fin && pend_vld_q) begin
        pend_vld_q <= 1'b0;
        res_vld_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      src_q   <= src_addr_i;
      dst_q   <= dst_addr_i;
      tag_q   <= TAG_BITS'(packet_tag_i);
      now_q   <= now_i;
      reid_q  <= reply_eid_i;
      rrloc_q <= reply_rloc_i;
      reply_q <= (dst_addr_i == own_q);
      stray_q <= (dst_addr_i == own_q) && (src_addr_i != mapdb_q);
    end
    if (emit_v) begin
      pend_q <= emit_r;
      out_q  <= pend_q;
      last_q <= 1'b0;
    end else if (fin && pend_vld_q) begin
      out_q  <= pend_q;
      last_q <= 1'b1;
    end
  end

  assign result_valid_o = res_vld_q;
  assign kind_o         = out_q.kind;
  assign out_tag_o      = out_q.tag;
  assign out_src_o      = out_q.src;
  assign out_dst_o      = out_q.dst;
  assign request_eid_o  = out_q.reid;
  assign last_o         = last_q;

endmodule

`default_nettype wire

### rtl/core/imc_ram.sv
// Simple dual-port synchronous RAM with registered read.
// Generic storage used by imc_cache and the top level.
`default_nettype none

module imc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/imc_cache.sv
// Map cache: entry memory, valid bits, replacement head and the scan engine
// that purges expired entries and looks up two identifiers. Uses imc_pkg, imc_ram.
`default_nettype none

module imc_cache
  import imc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES = CacheEntriesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cache_cmd_t          cmd_i,
  input  wire logic [AddrBits-1:0] key_s_i,
  input  wire logic [AddrBits-1:0] key_d_i,
  input  wire logic [AddrBits-1:0] now_i,
  input  wire logic [AddrBits-1:0] ins_eid_i,
  input  wire logic [AddrBits-1:0] ins_rloc_i,
  input  wire logic [AddrBits-1:0] ins_expiry_i,
  output cache_res_t               res_o
);

  localparam int unsigned Aw = $clog2(CACHE_ENTRIES);
  localparam logic [Aw-1:0] LastIdx = Aw'(CACHE_ENTRIES - 1);

  logic [CACHE_ENTRIES-1:0] valid_q;
  logic [Aw-1:0]            head_q;
  logic                     issue_on_q;
  logic [Aw-1:0]            issue_idx_q;
  logic                     rd_vld_q;
  logic [Aw-1:0]            rd_idx_q;
  logic                     purge_q;
  logic [AddrBits-1:0]      key_s_q, key_d_q, now_q;
  logic                     free_found_q;
  logic [Aw-1:0]            free_idx_q;
  logic                     done_q, hit_s_q, hit_d_q;
  logic [AddrBits-1:0]      rloc_s_q, rloc_d_q;

  logic [$bits(cache_entry_t)-1:0] rd_data;
  cache_entry_t                    rd_ent;
  cache_entry_t                    wr_ent;
  logic [Aw-1:0]                   ins_slot;
  logic                            expired;
  logic                            alive;

  assign wr_ent   = '{expiry: ins_expiry_i, rloc: ins_rloc_i, eid: ins_eid_i};
  assign ins_slot = free_found_q ? free_idx_q : head_q;

  imc_ram #(
    .WIDTH ($bits(cache_entry_t)),
    .DEPTH (CACHE_ENTRIES)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.insert),
    .wr_addr_i (ins_slot),
    .wr_data_i (wr_ent),
    .rd_en_i   (issue_on_q),
    .rd_addr_i (issue_idx_q),
    .rd_data_o (rd_data)
  );

  assign rd_ent  = cache_entry_t'(rd_data);
  assign expired = purge_q && valid_q[rd_idx_q] && (rd_ent.expiry < now_q);
  assign alive   = valid_q[rd_idx_q] && !expired;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      head_q       <= '0;
      issue_on_q   <= 1'b0;
      issue_idx_q  <= '0;
      rd_vld_q     <= 1'b0;
      rd_idx_q     <= '0;
      done_q       <= 1'b0;
      hit_s_q      <= 1'b0;
      hit_d_q      <= 1'b0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      purge_q      <= 1'b0;
    end else begin
      done_q   <= 1'b0;
      rd_vld_q <= issue_on_q;
      rd_idx_q <= issue_idx_q;
      if (issue_on_q) begin
        if (issue_idx_q == LastIdx) begin
          issue_on_q <= 1'b0;
        end else begin
          issue_idx_q <= issue_idx_q + 1'b1;
        end
      end
      if (cmd_i.start) begin
        issue_on_q   <= 1'b1;
        issue_idx_q  <= '0;
        purge_q      <= cmd_i.purge;
        hit_s_q      <= 1'b0;
        hit_d_q      <= 1'b0;
        free_found_q <= 1'b0;
      end else if (rd_vld_q) begin
        if (expired) begin
          valid_q[rd_idx_q] <= 1'b0;
        end
        if (alive && (rd_ent.eid == key_s_q) && !hit_s_q) begin
          hit_s_q <= 1'b1;
        end
        if (alive && (rd_ent.eid == key_d_q) && !hit_d_q) begin
          hit_d_q <= 1'b1;
        end
        if (!alive && !free_found_q) begin
          free_found_q <= 1'b1;
          free_idx_q   <= rd_idx_q;
        end
        done_q <= (rd_idx_q == LastIdx);
      end
      if (cmd_i.insert) begin
        valid_q[ins_slot] <= 1'b1;
        if (!free_found_q) begin
          head_q <= (head_q == LastIdx) ? '0 : head_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_s_q <= key_s_i;
      key_d_q <= key_d_i;
      now_q   <= now_i;
    end else if (rd_vld_q) begin
      if (alive && (rd_ent.eid == key_s_q) && !hit_s_q) begin
        rloc_s_q <= rd_ent.rloc;
      end
      if (alive && (rd_ent.eid == key_d_q) && !hit_d_q) begin
        rloc_d_q <= rd_ent.rloc;
      end
    end
  end

  assign res_o = '{done: done_q, hit_s: hit_s_q, hit_d: hit_d_q,
                   rloc_s: rloc_s_q, rloc_d: rloc_d_q};

endmodule

`default_nettype wire

### rtl/core/imc_checker.sv
// Port-level checks of the map cache forwarder, bound to the top level.
// Uses imc_pkg.
`default_nettype none

module imc_checker
  import imc_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  result_valid_o,
  input wire logic [1:0]            kind_o,
  input wire logic [OutTagBits-1:0] out_tag_o,
  input wire logic [AddrBits-1:0]   request_eid_o,
  input wire logic                  last_o
);

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !start) |=> !result_valid_o)
    else $error("Result transaction while idle.");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("Accepted transaction did not raise busy.");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !result_valid_o)
    else $error("Result transaction directly after a final one.");

  a_req_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (kind_o == KIND_REQ)) |-> (out_tag_o == '0))
    else $error("Map request carries a packet tag.");

  a_eid_only_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (kind_o != KIND_REQ)) |-> (request_eid_o == '0))
    else $error("Requested identifier set outside a map request.");

endmodule

bind itr_map_cache_forwarder imc_checker u_imc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .kind_o         (kind_o),
  .out_tag_o      (out_tag_o),
  .request_eid_o  (request_eid_o),
  .last_o         (last_o)
);

`default_nettype wire

### tb/imc_checker.sv
// Scoreboard for the map cache forwarder: predicts results from accepted packet
// transactions and register writes, and compares them. Depends on imc_pkg.
`timescale 1ns / 100ps

module imc_scoreboard
  import imc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [AddrBits-1:0]   cfg_wdata_i,
  input  logic [AddrBits-1:0]   src_addr_i,
  input  logic [AddrBits-1:0]   dst_addr_i,
  input  logic [OutTagBits-1:0] packet_tag_i,
  input  logic [AddrBits-1:0]   now_i,
  input  logic [AddrBits-1:0]   reply_eid_i,
  input  logic [AddrBits-1:0]   reply_rloc_i,
  input  logic                  result_valid_o,
  input  logic [1:0]            kind_o,
  input  logic [OutTagBits-1:0] out_tag_o,
  input  logic [AddrBits-1:0]   out_src_o,
  input  logic [AddrBits-1:0]   out_dst_o,
  input  logic [AddrBits-1:0]   request_eid_o,
  input  logic                  last_o,
  output int                    errors,
  output int                    pending
);

  localparam int Entries = CacheEntriesDef;
  localparam int Depth   = QueueDepthDef;

  typedef struct {
    kind_e                 kind;
    logic [OutTagBits-1:0] tag;
    logic [AddrBits-1:0]   src;
    logic [AddrBits-1:0]   dst;
    logic [AddrBits-1:0]   reid;
    logic                  last;
  } outcome_t;

  logic [31:0] own_q, mapdb_q, ttl_q;
  logic [31:0] map_eid [Entries];
  logic [31:0] map_rloc [Entries];
  logic [31:0] map_exp [Entries];
  logic        map_live [Entries];
  int          map_head;
  logic [31:0] park_src [Depth];
  logic [31:0] park_dst [Depth];
  logic [15:0] park_tag [Depth];
  int          park_n;
  outcome_t    awaited [$];

  assign pending = awaited.size();

  function automatic bit resolve(input logic [31:0] eid, output logic [31:0] rloc);
    rloc = '0;
    for (int i = 0; i < Entries; i++)
      if (map_live[i] && map_eid[i] == eid) begin
        rloc = map_rloc[i];
        return 1;
      end
    return 0;
  endfunction

  task automatic push_outcome(input kind_e k, input logic [15:0] t, input logic [31:0] s,
                              input logic [31:0] d, input logic [31:0] e);
    outcome_t o;
    o.kind = k; o.tag = t; o.src = s; o.dst = d; o.reid = e; o.last = 1'b0;
    awaited = {awaited, o};
  endtask

  task automatic forward_packet(input logic [31:0] src, input logic [31:0] dst,
                                input logic [15:0] tag, input logic [31:0] now,
                                input logic [31:0] reid, input logic [31:0] rrloc);
    int base_n, w, slot;
    bit hs, hd;
    logic [31:0] srl, drl;
    base_n = awaited.size();
    w = 0;
    for (int i = 0; i < Entries; i++)
      if (map_live[i] && map_exp[i] < now) map_live[i] = 1'b0;
    if (dst == own_q) begin
      if (src != mapdb_q) return;
      if (rrloc == 0) begin
        for (int r = 0; r < park_n; r++)
          if (park_src[r] == reid || park_dst[r] == reid) begin
            push_outcome(KIND_DROP, park_tag[r], '0, '0, '0);
          end else begin
            park_src[w] = park_src[r]; park_dst[w] = park_dst[r];
            park_tag[w] = park_tag[r]; w++;
          end
      end else begin
        slot = -1;
        for (int i = 0; i < Entries; i++)
          if (!map_live[i] && slot < 0) slot = i;
        if (slot < 0) begin
          slot = map_head;
          map_head = (map_head + 1) % Entries;
        end
        map_eid[slot] = reid; map_rloc[slot] = rrloc;
        map_exp[slot] = now + ttl_q; map_live[slot] = 1'b1;
        for (int r = 0; r < park_n; r++) begin
          hs = resolve(park_src[r], srl);
          hd = resolve(park_dst[r], drl);
          if (hs && hd) begin
            push_outcome(KIND_FWD, park_tag[r], srl, drl, '0);
          end else begin
            park_src[w] = park_src[r]; park_dst[w] = park_dst[r];
            park_tag[w] = park_tag[r]; w++;
          end
        end
      end
      park_n = w;
    end else begin
      hs = resolve(src, srl);
      hd = resolve(dst, drl);
      if (hs && hd) begin
        push_outcome(KIND_FWD, tag, srl, drl, '0);
      end else begin
        if (!hs) push_outcome(KIND_REQ, '0, own_q, mapdb_q, src);
        if (!hd) push_outcome(KIND_REQ, '0, own_q, mapdb_q, dst);
        if (park_n < Depth) begin
          park_src[park_n] = src; park_dst[park_n] = dst;
          park_tag[park_n] = tag; park_n++;
        end else begin
          push_outcome(KIND_DROP, tag, '0, '0, '0);
        end
      end
    end
    if (awaited.size() > base_n) awaited[awaited.size()-1].last = 1'b1;
  endtask

  task automatic compare_result();
    outcome_t o;
    if (awaited.size() == 0) begin
      $display("%0t: unexpected result kind %0d tag %h", $time, kind_o, out_tag_o);
      errors++;
      return;
    end
    o = awaited.pop_front();
    if (kind_o !== o.kind || out_tag_o !== o.tag || out_src_o !== o.src ||
        out_dst_o !== o.dst || request_eid_o !== o.reid || last_o !== o.last) begin
      $display("%0t: mismatch expected %0d %h %h %h %h %b actual %0d %h %h %h %h %b",
               $time, o.kind, o.tag, o.src, o.dst, o.reid, o.last, kind_o, out_tag_o,
               out_src_o, out_dst_o, request_eid_o, last_o);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q = '0; mapdb_q = '0; ttl_q = '0; map_head = 0; park_n = 0; errors = 0;
      for (int i = 0; i < Entries; i++) map_live[i] = 1'b0;
      awaited.delete();
    end else begin
      if (result_valid_o) compare_result();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_OWN_ADDRESS: own_q = cfg_wdata_i;
          REG_MAPDB_ADDRESS: mapdb_q = cfg_wdata_i;
          REG_CACHE_TTL: ttl_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (start && !busy)
        forward_packet(src_addr_i, dst_addr_i, packet_tag_i, now_i, reply_eid_i,
                       reply_rloc_i);
    end
  end

endmodule

### tb/testbench.sv
// Top of the map cache forwarder testbench: clock, reset, register writes
// and packet stimulus. Depends on imc_pkg, imc_scoreboard and the block.
`timescale 1ns / 100ps

module testbench
  import imc_pkg::*;
();

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = REG_OWN_ADDRESS;
  logic [AddrBits-1:0]   cfg_wdata_i = '0;
  logic [AddrBits-1:0]   src_addr_i = '0, dst_addr_i = '0, now_i = '0;
  logic [AddrBits-1:0]   reply_eid_i = '0, reply_rloc_i = '0;
  logic [OutTagBits-1:0] packet_tag_i = '0;
  logic                  result_valid_o, last_o;
  logic [1:0]            kind_o;
  logic [OutTagBits-1:0] out_tag_o;
  logic [AddrBits-1:0]   out_src_o, out_dst_o, request_eid_o;
  int                    errors, pending;
  int                    quiet_cycles = 0;
  bit                    calm = 1'b0;
  logic [31:0]           own_a, mapdb_a, clock_now;
  logic [31:0]           eid_pool [8];

  always #10 clk_i = ~clk_i;

  itr_map_cache_forwarder i_dut (.*);
  imc_scoreboard i_checker (.*);

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic set_reg(input logic [CfgIdxBits-1:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic send_packet(input logic [31:0] s, input logic [31:0] d,
                             input logic [15:0] t, input logic [31:0] n,
                             input logic [31:0] re, input logic [31:0] rl);
    if (!calm && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    start <= 1'b1; src_addr_i <= s; dst_addr_i <= d; packet_tag_i <= t;
    now_i <= n; reply_eid_i <= re; reply_rloc_i <= rl;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (busy || pending != 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
  endtask

  task automatic configure(input logic [31:0] o, input logic [31:0] m, input logic [31:0] ttl);
    own_a = o; mapdb_a = m;
    set_reg(REG_OWN_ADDRESS, o);
    set_reg(REG_MAPDB_ADDRESS, m);
    set_reg(REG_CACHE_TTL, ttl);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    logic [31:0] s, d;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      clock_now = clock_now + $urandom_range(0, 3);
      s = eid_pool[$urandom_range(0, 7)];
      d = eid_pool[$urandom_range(0, 7)];
      if (pick < 5) begin
        if (d == own_a) d = d ^ 32'h1;
        send_packet(s, d, 16'($urandom), clock_now, $urandom, $urandom);
      end else if (pick < 8) begin
        send_packet(mapdb_a, own_a, 16'($urandom), clock_now, eid_pool[$urandom_range(0, 7)],
                    $urandom_range(0, 5) == 0 ? 32'h0 : $urandom);
      end else if (pick == 8) begin
        send_packet($urandom, own_a, 16'($urandom), clock_now, $urandom, $urandom);
      end else begin
        send_packet($urandom, $urandom, 16'($urandom), $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (eid_pool[i]) eid_pool[i] = $urandom;
    eid_pool[0] = 32'hFFFF_FFFF;
    eid_pool[1] = 32'h0000_0001;
    configure(32'hA000_0001, 32'hB000_0002, 32'hFFFF_FFFF);
    clock_now = 32'd100;
    send_packet(eid_pool[2], eid_pool[3], 16'hFFFF, clock_now, '0, '0);
    send_packet(eid_pool[4], eid_pool[4], 16'h0000, clock_now, '0, '0);
    send_packet(32'h1234_5678, own_a, 16'h5555, clock_now, eid_pool[2], 32'h1);
    send_packet(mapdb_a, own_a, 16'hAAAA, clock_now, eid_pool[2], 32'hFFFF_FFFF);
    send_packet(mapdb_a, own_a, 16'h1, clock_now, eid_pool[3], 32'hC0DE_0003);
    send_packet(mapdb_a, own_a, 16'h2, clock_now, eid_pool[3], 32'hC0DE_0004);
    send_packet(eid_pool[2], eid_pool[3], 16'h1357, clock_now, '0, '0);
    send_packet(mapdb_a, own_a, 16'h3, clock_now, eid_pool[4], 32'h0);
    for (int i = 0; i < 17; i++)
      send_packet(eid_pool[5], eid_pool[6], 16'(i), clock_now, '0, '0);
    for (int i = 0; i < 34; i++)
      send_packet(mapdb_a, own_a, 16'(i), clock_now, $urandom, $urandom | 32'h1);
    send_packet(eid_pool[0], eid_pool[1], 16'h7, 32'hFFFF_FFFF, '0, '0);
    drain();
    configure(32'h0, 32'h0, 32'h0);
    clock_now = 32'h10;
    random_phase(30);
    drain();
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd6);
    random_phase(30);
    drain();
    configure($urandom, $urandom, 32'd40);
    calm = 1'b1;
    random_phase(30);
    drain();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
